### design/fsp_pkg.sv
// shared types and constants of the fasta stream parser
// no dependencies; compiled first

package fsp_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;

    localparam logic [2:0] KIND_ID   = 3'd0;
    localparam logic [2:0] KIND_DESC = 3'd1;
    localparam logic [2:0] KIND_CODE = 3'd2;
    localparam logic [2:0] KIND_HDR  = 3'd3;
    localparam logic [2:0] KIND_END  = 3'd4;
    localparam logic [2:0] KIND_BAD  = 3'd5;

    localparam logic [2:0] TSEL_DNA_INDEX = 3'd1;
    localparam logic [2:0] TSEL_LAST      = 3'd4;
    localparam logic [2:0] TSEL_RESET     = 3'd1;
    localparam int NUM_TABLES = 5;
    localparam int NUM_LETTERS = 26;

    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;

    // bit 8 set marks a letter that is bad in that table
    localparam logic [8:0] CB = 9'h100;

    localparam logic [8:0] LETTER_CODE [NUM_TABLES][NUM_LETTERS] = '{
        '{9'd65, CB, 9'd67, CB, CB, CB, 9'd71, CB, CB, CB, CB, CB, CB,
          9'd78, CB, CB, CB, CB, CB, 9'd84, CB, CB, CB, CB, CB, CB},
        '{9'd0, CB, 9'd1, CB, CB, CB, 9'd2, CB, CB, CB, CB, CB, CB,
          9'd4, CB, CB, CB, CB, CB, 9'd3, CB, CB, CB, CB, CB, CB},
        '{9'd1, CB, 9'd8, CB, CB, CB, 9'd4, CB, CB, CB, CB, CB, CB,
          9'd15, CB, CB, CB, CB, CB, 9'd2, CB, CB, CB, CB, CB, CB},
        '{9'd65, 9'd88, 9'd67, 9'd68, 9'd69, 9'd70, 9'd71, 9'd72, 9'd73, CB,
          9'd75, 9'd76, 9'd77, 9'd78, CB, 9'd80, 9'd81, 9'd82, 9'd83, 9'd84,
          CB, 9'd86, 9'd87, 9'd88, 9'd89, 9'd88},
        '{9'd0, 9'd21, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, CB,
          9'd8, 9'd9, 9'd10, 9'd11, CB, 9'd12, 9'd13, 9'd14, 9'd15, 9'd16,
          CB, 9'd17, 9'd18, 9'd21, 9'd20, 9'd21}
    };

    typedef struct packed {
        logic       eos;
        logic [7:0] data;
        logic       gt;
        logic       nl;
        logic       blank;
        logic       ign;
        logic       bad;
        logic [7:0] code;
    } t_cls;

endpackage

### design/fsp_if.sv
// channel interfaces of the fasta stream parser
// depends on nothing but the package order

interface fsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_stream;
    modport source (output valid, output byte_in, output end_of_stream, input ready);
    modport sink (input valid, input byte_in, input end_of_stream, output ready);
endinterface

interface fsp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [31:0] line_number;
    logic [31:0] base_count;
    modport source (output valid, output kind, output value, output line_number,
                    output base_count, input ready);
    modport sink (input valid, input kind, input value, input line_number,
                  input base_count, output ready);
endinterface

interface fsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] table_select;
    modport source (output valid, output table_select, input ready);
    modport sink (input valid, input table_select, output ready);
endinterface

### design/fsp_front.sv
// front end: table select register and byte classification
// uses fsp_pkg and the channel interfaces

module fsp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fsp_byte_if.sink        i_in,
    fsp_cfg_if.sink         i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output fsp_pkg::t_cls   o_cls
);

    logic [2:0] r_table_sel;
    logic [2:0] tsel;
    logic [7:0] b;
    logic [7:0] upper;
    logic [4:0] lidx;
    logic [8:0] entry;
    logic       letter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_sel <= fsp_pkg::TSEL_RESET;
        end else if (i_cfg.valid) begin
            r_table_sel <= i_cfg.table_select;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full;

    always_comb begin
        b      = i_in.byte_in;
        tsel   = (r_table_sel > fsp_pkg::TSEL_LAST) ? fsp_pkg::TSEL_DNA_INDEX : r_table_sel;
        upper  = (b inside {[8'd97:8'd122]}) ? (b - 8'd32) : b;
        letter = upper inside {[8'd65:8'd90]};
        lidx   = letter ? (upper[4:0] - 5'd1) : 5'd0;
        entry  = fsp_pkg::LETTER_CODE[tsel][lidx];

        o_cls.eos   = i_in.end_of_stream;
        o_cls.data  = b;
        o_cls.gt    = (b == fsp_pkg::CH_GT);
        o_cls.nl    = (b == fsp_pkg::CH_NL);
        o_cls.blank = (b == fsp_pkg::CH_SPACE) || (b == fsp_pkg::CH_TAB);
        o_cls.ign   = o_cls.blank || o_cls.nl || (b inside {[8'd48:8'd57]});
        o_cls.bad   = !o_cls.ign && (!letter || entry[8]);
        o_cls.code  = entry[7:0];
    end

endmodule

### design/fsp_queue.sv
// two word queue between classifier and record state machine
// uses fsp_pkg

module fsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fsp_pkg::t_cls   i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output fsp_pkg::t_cls   o_data
);

    fsp_pkg::t_cls              r_mem [fsp_pkg::QUEUE_DEPTH];
    logic [fsp_pkg::QPTR_W-1:0] r_wr;
    logic [fsp_pkg::QPTR_W-1:0] r_rd;
    logic [fsp_pkg::QPTR_W:0]   r_cnt;
    logic [fsp_pkg::QPTR_W:0]   n_cnt;

    assign o_full  = (r_cnt == (fsp_pkg::QPTR_W+1)'(fsp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop && o_valid) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

### design/fsp_back.sv
// back end: record state machine, line and base counters, result register
// uses fsp_pkg and fsp_result_if

module fsp_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fsp_pkg::t_cls   i_cls,
    output logic            o_pop,
    fsp_result_if.source    o_out
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_ID    = 3'd1;
    localparam logic [2:0] PH_BLANK = 3'd2;
    localparam logic [2:0] PH_DESC  = 3'd3;
    localparam logic [2:0] PH_SEQ   = 3'd4;
    localparam logic [2:0] PH_ERROR = 3'd5;

    logic [2:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_line, n_line;
    logic [COUNT_WIDTH-1:0] r_bases, n_bases;
    logic                   r_out_valid;
    logic [2:0]             r_kind;
    logic [7:0]             r_value;
    logic [31:0]            r_line_out;
    logic [31:0]            r_bases_out;

    logic                   emit;
    logic [2:0]             e_kind;
    logic [7:0]             e_value;
    logic [COUNT_WIDTH-1:0] e_line;
    logic [COUNT_WIDTH-1:0] e_bases;
    logic [COUNT_WIDTH-1:0] line_inc;
    logic [COUNT_WIDTH-1:0] seq_base;
    logic [COUNT_WIDTH-1:0] bases_inc;
    logic [COUNT_WIDTH-1:0] seq_line;

    assign o_pop = i_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        line_inc  = (&r_line) ? r_line : (r_line + 1'b1);
        seq_base  = (r_phase == PH_START) ? '0 : r_bases;
        bases_inc = (&seq_base) ? seq_base : (seq_base + 1'b1);
        seq_line  = i_cls.nl ? line_inc : r_line;

        n_phase = r_phase;
        n_line  = r_line;
        n_bases = r_bases;
        emit    = 1'b0;
        e_kind  = fsp_pkg::KIND_ID;
        e_value = '0;
        e_line  = r_line;
        e_bases = '0;

        if (i_cls.eos) begin
            if (r_phase inside {PH_ID, PH_BLANK, PH_DESC, PH_SEQ}) begin
                emit    = 1'b1;
                e_kind  = fsp_pkg::KIND_END;
                e_bases = r_bases;
            end
            n_phase = PH_START;
            n_line  = COUNT_WIDTH'(1);
            n_bases = '0;
        end else begin
            case (r_phase)
                PH_START, PH_SEQ: begin
                    if (i_cls.gt) begin
                        if (r_phase == PH_SEQ) begin
                            emit    = 1'b1;
                            e_kind  = fsp_pkg::KIND_END;
                            e_bases = r_bases;
                        end
                        n_phase = PH_ID;
                        n_bases = '0;
                    end else begin
                        n_phase = PH_SEQ;
                        n_line  = seq_line;
                        n_bases = seq_base;
                        e_line  = seq_line;
                        if (i_cls.bad) begin
                            n_phase = PH_ERROR;
                            emit    = 1'b1;
                            e_kind  = fsp_pkg::KIND_BAD;
                            e_value = i_cls.data;
                            e_bases = seq_base;
                        end else if (!i_cls.ign) begin
                            n_bases = bases_inc;
                            emit    = 1'b1;
                            e_kind  = fsp_pkg::KIND_CODE;
                            e_value = i_cls.code;
                            e_bases = bases_inc;
                        end
                    end
                end
                PH_ID, PH_BLANK, PH_DESC: begin
                    if (i_cls.nl) begin
                        n_line  = line_inc;
                        n_phase = PH_SEQ;
                        emit    = 1'b1;
                        e_kind  = fsp_pkg::KIND_HDR;
                        e_line  = line_inc;
                    end else if (i_cls.blank && (r_phase != PH_DESC)) begin
                        n_phase = PH_BLANK;
                    end else begin
                        emit    = 1'b1;
                        e_value = i_cls.data;
                        if (r_phase == PH_ID) begin
                            e_kind = fsp_pkg::KIND_ID;
                        end else begin
                            e_kind  = fsp_pkg::KIND_DESC;
                            n_phase = PH_DESC;
                        end
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_line      <= COUNT_WIDTH'(1);
            r_bases     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_line  <= n_line;
                r_bases <= n_bases;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kind      <= e_kind;
            r_value     <= e_value;
            r_line_out  <= 32'(e_line);
            r_bases_out <= 32'(e_bases);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_kind;
    assign o_out.value       = r_value;
    assign o_out.line_number = r_line_out;
    assign o_out.base_count  = r_bases_out;

endmodule

### design/fasta_stream_parser.sv
// top level of the fasta stream parser
// uses fsp_pkg, the channel interfaces, fsp_front, fsp_queue and fsp_back
//
// i_in carries one file byte per word, with end_of_stream marking the end of
// a file (the byte of that word is ignored). o_out carries one result word:
// id or description byte, sequence code, header done, record end or bad
// character, with the current line and the base count of the record.
// i_cfg writes table_select (dna text, dna index, dna binary, protein text,
// protein index) and is always ready; write it only while the block is idle.
// A byte is classified on arrival and stored in a two word queue; the record
// state machine takes one word per cycle from it while the output register
// is empty or being read, and loads any result into it. An accepted byte
// passes the queue and then the output register before it shows on o_out.
// When o_out stalls, the output register holds, the queue fills within two
// bytes and i_in.ready drops. Reset selects dna index, returns to record
// start with line 1 and no bases, and empties the queue and output register.

module fasta_stream_parser #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fsp_byte_if.sink      i_in,
    fsp_cfg_if.sink       i_cfg,
    fsp_result_if.source  o_out
);

    fsp_pkg::t_cls front_cls;
    fsp_pkg::t_cls queue_cls;
    logic          push;
    logic          full;
    logic          q_valid;
    logic          pop;

    fsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_cls   (front_cls)
    );

    fsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (queue_cls)
    );

    fsp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cls   (queue_cls),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### design/fsp_checker.sv
// port level checks of the fasta stream parser, bound to the top level
// uses fsp_pkg and fasta_stream_parser

module fsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [7:0]  i_value,
    input logic [31:0] i_line_number,
    input logic [31:0] i_base_count
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_value) && $stable(i_base_count))
        else $error("result word changed while stalled");

    a_header_no_bases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == fsp_pkg::KIND_ID || i_kind == fsp_pkg::KIND_DESC
            || i_kind == fsp_pkg::KIND_HDR) |-> i_base_count == 32'd0)
        else $error("header word with nonzero base count");

    a_marker_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == fsp_pkg::KIND_HDR || i_kind == fsp_pkg::KIND_END)
            |-> i_value == 8'd0)
        else $error("header done or record end with nonzero value");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_line_number != 32'd0)
        else $error("line number zero");

endmodule

bind fasta_stream_parser fsp_checker u_fsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_kind        (o_out.kind),
    .i_value       (o_out.value),
    .i_line_number (o_out.line_number),
    .i_base_count  (o_out.base_count)
);

### sim/fasta_stream_parser_tb.sv
// self-checking testbench of fasta_stream_parser: directed bytes, then random fasta records
// and noise; depends on fsp_pkg, the channel interfaces and the design sources

module fasta_stream_parser_tb;

    localparam int COUNT_W = 32;
    localparam int RANDOM_PER_TABLE = 275;
    localparam int CODE_SKIP = -1;
    localparam int CODE_BAD = -2;

    typedef enum logic [2:0] {
        TBL_DNA_TEXT   = 3'd0,
        TBL_DNA_INDEX  = 3'd1,
        TBL_DNA_BIN    = 3'd2,
        TBL_PROT_TEXT  = 3'd3,
        TBL_PROT_INDEX = 3'd4,
        TBL_SPARE_LO   = 3'd5,
        TBL_SPARE      = 3'd7
    } t_table_sel;

    typedef enum logic [2:0] {
        PS_START, PS_ID, PS_BLANK, PS_DESC, PS_SEQ, PS_ERROR
    } t_parse_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [31:0] line_no;
        logic [31:0] bases;
    } t_parse_result;

    typedef struct {
        logic          eos;
        logic [7:0]    data;
        bit            fixed;
        bit            has_res;
        t_parse_result res;
    } t_script_row;

    localparam logic [2:0] SWEEP [7] = '{TBL_DNA_TEXT, TBL_PROT_INDEX, TBL_DNA_BIN,
        TBL_PROT_TEXT, TBL_SPARE_LO, TBL_SPARE, TBL_DNA_INDEX};

    logic i_clk;
    logic i_rst_n;

    fsp_byte_if   byte_ch();
    fsp_cfg_if    cfg_ch();
    fsp_result_if out_ch();

    fasta_stream_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // parser state mirrored by the testbench
    logic [2:0]         cur_table = TBL_DNA_INDEX;
    t_parse_phase       parse_ph = PS_START;
    logic [COUNT_W-1:0] line_cnt = 1;
    logic [COUNT_W-1:0] base_cnt = 0;
    bit                 rec_open = 0;

    t_parse_result pending_results [$];
    int  fed_bytes = 0;
    int  results_seen = 0;
    int  ends_seen = 0;
    int  bads_seen = 0;
    int  tables_used = 0;
    int  mismatches = 0;
    int  sink_hold = 0;
    bit  calm = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results still pending", $realtime, pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] x);
        return (x == {COUNT_W{1'b1}}) ? x : x + 1'b1;
    endfunction

    function automatic int letter_to_code(input logic [2:0] tsel, input logic [7:0] up);
        case (tsel)
            TBL_DNA_TEXT: begin
                case (up)
                    "A", "C", "G", "N", "T": return up;
                    default: return CODE_BAD;
                endcase
            end
            TBL_DNA_BIN: begin
                case (up)
                    "A": return 1;
                    "C": return 8;
                    "G": return 4;
                    "N": return 15;
                    "T": return 2;
                    default: return CODE_BAD;
                endcase
            end
            TBL_PROT_TEXT: begin
                case (up)
                    "J", "O", "U": return CODE_BAD;
                    "B", "X", "Z": return "X";
                    default: return up;
                endcase
            end
            TBL_PROT_INDEX: begin
                case (up)
                    "A": return 0;
                    "C": return 1;
                    "D": return 2;
                    "E": return 3;
                    "F": return 4;
                    "G": return 5;
                    "H": return 6;
                    "I": return 7;
                    "K": return 8;
                    "L": return 9;
                    "M": return 10;
                    "N": return 11;
                    "P": return 12;
                    "Q": return 13;
                    "R": return 14;
                    "S": return 15;
                    "T": return 16;
                    "V": return 17;
                    "W": return 18;
                    "Y": return 20;
                    "B", "X", "Z": return 21;
                    default: return CODE_BAD;
                endcase
            end
            default: begin
                case (up)
                    "A": return 0;
                    "C": return 1;
                    "G": return 2;
                    "T": return 3;
                    "N": return 4;
                    default: return CODE_BAD;
                endcase
            end
        endcase
    endfunction

    function automatic int residue_code(input logic [7:0] b);
        logic [2:0] tsel;
        logic [7:0] up;
        tsel = (cur_table > TBL_PROT_INDEX) ? TBL_DNA_INDEX : cur_table;
        up = b;
        if (b > 8'd127) return CODE_BAD;
        if (b == fsp_pkg::CH_SPACE || b == fsp_pkg::CH_TAB || b == fsp_pkg::CH_NL)
            return CODE_SKIP;
        if (b >= "0" && b <= "9") return CODE_SKIP;
        if (b >= "a" && b <= "z") up = b - 8'd32;
        if (up >= "A" && up <= "Z") return letter_to_code(tsel, up);
        return CODE_BAD;
    endfunction

    function automatic bit sequence_byte(input logic [7:0] b, output t_parse_result r);
        int code;
        if (b == fsp_pkg::CH_NL) line_cnt = sat_inc(line_cnt);
        code = residue_code(b);
        r = '0;
        if (code == CODE_BAD) begin
            parse_ph = PS_ERROR;
            r = '{fsp_pkg::KIND_BAD, b, line_cnt[31:0], base_cnt[31:0]};
            return 1'b1;
        end
        if (code < 0) return 1'b0;
        base_cnt = sat_inc(base_cnt);
        r = '{fsp_pkg::KIND_CODE, code[7:0], line_cnt[31:0], base_cnt[31:0]};
        return 1'b1;
    endfunction

    function automatic bit parse_fasta_byte(input logic eos, input logic [7:0] b,
                                            output t_parse_result r);
        bit got;
        bit blank;
        got = 1'b0;
        r = '0;
        blank = (b == fsp_pkg::CH_SPACE || b == fsp_pkg::CH_TAB);
        if (eos) begin
            if (parse_ph != PS_ERROR && parse_ph != PS_START && rec_open) begin
                r = '{fsp_pkg::KIND_END, 8'd0, line_cnt[31:0], base_cnt[31:0]};
                got = 1'b1;
            end
            parse_ph = PS_START;
            line_cnt = 1;
            base_cnt = 0;
            rec_open = 1'b0;
            return got;
        end
        case (parse_ph)
            PS_START: begin
                rec_open = 1'b1;
                base_cnt = 0;
                if (b == fsp_pkg::CH_GT) begin
                    parse_ph = PS_ID;
                end else begin
                    parse_ph = PS_SEQ;
                    got = sequence_byte(b, r);
                end
            end
            PS_ID, PS_BLANK, PS_DESC: begin
                if (blank && parse_ph != PS_DESC) begin
                    parse_ph = PS_BLANK;
                end else if (b == fsp_pkg::CH_NL) begin
                    line_cnt = sat_inc(line_cnt);
                    parse_ph = PS_SEQ;
                    r = '{fsp_pkg::KIND_HDR, 8'd0, line_cnt[31:0], 32'd0};
                    got = 1'b1;
                end else if (parse_ph == PS_ID) begin
                    r = '{fsp_pkg::KIND_ID, b, line_cnt[31:0], 32'd0};
                    got = 1'b1;
                end else begin
                    parse_ph = PS_DESC;
                    r = '{fsp_pkg::KIND_DESC, b, line_cnt[31:0], 32'd0};
                    got = 1'b1;
                end
            end
            PS_SEQ: begin
                if (b == fsp_pkg::CH_GT) begin
                    r = '{fsp_pkg::KIND_END, 8'd0, line_cnt[31:0], base_cnt[31:0]};
                    got = 1'b1;
                    base_cnt = 0;
                    rec_open = 1'b1;
                    parse_ph = PS_ID;
                end else begin
                    got = sequence_byte(b, r);
                end
            end
            default: parse_ph = PS_ERROR;
        endcase
        return got;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] pick_residue();
        string pool;
        logic [7:0] c;
        if (cur_table == TBL_PROT_TEXT || cur_table == TBL_PROT_INDEX)
            pool = "ABCDEFGHIKLMNPQRSTVWXYZ";
        else
            pool = "ACGTN";
        c = pool[$urandom_range(0, pool.len() - 1)];
        if ($urandom_range(0, 1) == 1) c = c | 8'h20;
        return c;
    endfunction

    function automatic t_script_row row_pred(input logic eos, input logic [7:0] d);
        t_script_row s;
        s.eos = eos;
        s.data = d;
        s.fixed = 1'b0;
        s.has_res = 1'b0;
        s.res = '0;
        return s;
    endfunction

    function automatic t_script_row row_fixed(input logic eos, input logic [7:0] d,
                                              input bit has, input logic [2:0] k,
                                              input logic [7:0] v, input logic [31:0] ln,
                                              input logic [31:0] bc);
        t_script_row s;
        s.eos = eos;
        s.data = d;
        s.fixed = 1'b1;
        s.has_res = has;
        s.res = '{k, v, ln, bc};
        return s;
    endfunction

    task automatic feed(input logic eos, input logic [7:0] d, output bit got,
                        output t_parse_result r);
        int gap;
        bit live;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.byte_in <= d;
        byte_ch.end_of_stream <= eos;
        do @(posedge i_clk); while (!byte_ch.ready);
        live = (parse_ph != PS_ERROR);
        got = parse_fasta_byte(eos, d, r);
        if (live) fed_bytes++;
    endtask

    task automatic feed_checked(input logic eos, input logic [7:0] d);
        bit got;
        t_parse_result r;
        feed(eos, d, got, r);
        if (got) pending_results.push_back(r);
    endtask

    task automatic wait_results_flushed();
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle_idle();
        wait_results_flushed();
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_table(input logic [2:0] sel);
        cfg_ch.valid <= 1'b1;
        cfg_ch.table_select <= sel;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_table = sel;
        tables_used++;
    endtask

    task automatic send_record();
        logic [7:0] txt [$];
        int r;
        if ($urandom_range(0, 99) < 75) begin
            txt.push_back(fsp_pkg::CH_GT);
            repeat ($urandom_range(0, 8))
                txt.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(33, 255))
                                                           : pick_residue());
            repeat ($urandom_range(0, 3))
                txt.push_back(($urandom_range(0, 1) == 1) ? fsp_pkg::CH_SPACE
                                                           : fsp_pkg::CH_TAB);
            repeat ($urandom_range(0, 12)) txt.push_back(8'($urandom_range(32, 255)));
            txt.push_back(fsp_pkg::CH_NL);
        end
        repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(1, 24)) begin
                r = $urandom_range(0, 99);
                if (r < 86)
                    txt.push_back(pick_residue());
                else if (r < 93)
                    txt.push_back(8'h30 + 8'($urandom_range(0, 9)));
                else
                    txt.push_back(($urandom_range(0, 1) == 1) ? fsp_pkg::CH_SPACE
                                                               : fsp_pkg::CH_TAB);
            end
            txt.push_back(fsp_pkg::CH_NL);
        end
        // occasional stray byte anywhere in the record
        if ($urandom_range(0, 9) == 0)
            txt.insert($urandom_range(0, txt.size()), 8'($urandom_range(0, 255)));
        foreach (txt[i]) begin
            if (parse_ph != PS_ERROR) feed_checked(1'b0, txt[i]);
        end
        if (parse_ph == PS_ERROR || $urandom_range(0, 6) == 0)
            feed_checked(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12))
            feed_checked($urandom_range(0, 19) == 0, 8'($urandom_range(0, 255)));
        feed_checked(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_random(input int quota);
        int start;
        start = fed_bytes;
        while (fed_bytes - start < quota) begin
            calm = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 8) send_noise();
            else send_record();
            if ($urandom_range(0, 29) == 0) wait_results_flushed();
        end
        feed_checked(1'b1, 8'($urandom_range(0, 255)));
        calm = 1'b0;
        settle_idle();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name,
                     want, got);
        end
    endtask

    task automatic check_result();
        t_parse_result e;
        results_seen++;
        if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, expected none, actual kind %0d value %0h",
                     $realtime, out_ch.kind, out_ch.value);
            return;
        end
        e = pending_results.pop_front();
        check_field("kind", 32'(e.kind), 32'(out_ch.kind));
        check_field("value", 32'(e.value), 32'(out_ch.value));
        check_field("line_number", e.line_no, out_ch.line_number);
        check_field("base_count", e.bases, out_ch.base_count);
        if (e.kind == fsp_pkg::KIND_END) ends_seen++;
        if (e.kind == fsp_pkg::KIND_BAD) bads_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_hold = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_result();
            if (sink_hold > 0) begin
                sink_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                sink_hold = calm ? 0 : idle_len();
                out_ch.ready <= (sink_hold == 0);
            end
        end
    end

    initial begin
        t_script_row script [$];
        bit got;
        t_parse_result r;

        i_rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.byte_in <= 8'd0;
        byte_ch.end_of_stream <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.table_select <= TBL_DNA_INDEX;

        // reset table is dna index
        script.push_back(row_fixed(1'b0, "A", 1'b1, fsp_pkg::KIND_CODE, 8'd0, 32'd1, 32'd1));
        script.push_back(row_pred(1'b0, "c"));
        script.push_back(row_pred(1'b0, fsp_pkg::CH_NL));
        script.push_back(row_pred(1'b0, "7"));
        script.push_back(row_pred(1'b0, "T"));
        script.push_back(row_fixed(1'b0, fsp_pkg::CH_GT, 1'b1, fsp_pkg::KIND_END, 8'd0,
                                   32'd2, 32'd3));
        script.push_back(row_pred(1'b0, "x"));
        script.push_back(row_fixed(1'b0, 8'hFF, 1'b1, fsp_pkg::KIND_ID, 8'hFF, 32'd2, 32'd0));
        script.push_back(row_pred(1'b0, fsp_pkg::CH_TAB));
        script.push_back(row_pred(1'b0, fsp_pkg::CH_SPACE));
        script.push_back(row_fixed(1'b0, 8'h00, 1'b1, fsp_pkg::KIND_DESC, 8'h00, 32'd2,
                                   32'd0));
        script.push_back(row_pred(1'b0, 8'h80));
        script.push_back(row_fixed(1'b0, fsp_pkg::CH_NL, 1'b1, fsp_pkg::KIND_HDR, 8'd0,
                                   32'd3, 32'd0));
        script.push_back(row_pred(1'b0, "g"));
        script.push_back(row_pred(1'b0, "N"));
        script.push_back(row_fixed(1'b1, 8'hA5, 1'b1, fsp_pkg::KIND_END, 8'd0, 32'd3, 32'd2));
        script.push_back(row_fixed(1'b1, 8'h5A, 1'b0, fsp_pkg::KIND_END, 8'd0, 32'd0, 32'd0));
        script.push_back(row_fixed(1'b0, fsp_pkg::CH_GT, 1'b0, fsp_pkg::KIND_ID, 8'd0,
                                   32'd0, 32'd0));
        script.push_back(row_fixed(1'b0, fsp_pkg::CH_NL, 1'b1, fsp_pkg::KIND_HDR, 8'd0,
                                   32'd2, 32'd0));
        script.push_back(row_fixed(1'b0, 8'hFF, 1'b1, fsp_pkg::KIND_BAD, 8'hFF, 32'd2, 32'd0));
        script.push_back(row_fixed(1'b0, "A", 1'b0, fsp_pkg::KIND_ID, 8'd0, 32'd0, 32'd0));
        script.push_back(row_fixed(1'b1, 8'hFF, 1'b0, fsp_pkg::KIND_END, 8'd0, 32'd0, 32'd0));
        script.push_back(row_pred(1'b0, fsp_pkg::CH_GT));
        script.push_back(row_pred(1'b0, "q"));
        script.push_back(row_fixed(1'b1, 8'h00, 1'b1, fsp_pkg::KIND_END, 8'd0, 32'd1, 32'd0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            feed(script[i].eos, script[i].data, got, r);
            if (script[i].fixed) begin
                if (script[i].has_res) pending_results.push_back(script[i].res);
            end else if (got) begin
                pending_results.push_back(r);
            end
        end
        settle_idle();

        foreach (SWEEP[i]) begin
            write_table(SWEEP[i]);
            run_random(RANDOM_PER_TABLE);
        end

        $display("fed %0d live bytes across the reset table and %0d written settings",
                 fed_bytes, tables_used);
        $display("checked %0d words: %0d record ends, %0d bad characters",
                 results_seen, ends_seen, bads_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
